// ----- design/ufr_pkg.sv -----
// Package for the USB data packet framer: operation codes, register indexes,
// byte-select codes, controller/datapath bundles and the CRC-16 byte update.
// Has no dependencies; all framer modules refer to it by scoped names.
package ufr_pkg;

	// Operation carried with each input beat.
	localparam logic [1:0] OP_DATA       = 2'd0;
	localparam logic [1:0] OP_FINAL      = 2'd1;
	localparam logic [1:0] OP_END        = 2'd2;
	localparam logic [1:0] OP_TOGGLE_RST = 2'd3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PID_DATA0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PID_DATA1 = 2'd1;

	localparam logic [7:0] PID_DATA0_RESET = 8'd195;
	localparam logic [7:0] PID_DATA1_RESET = 8'd75;

	// CRC-16, reflected form.
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// Packet overhead counted in the length byte: PID plus two CRC bytes.
	localparam logic [7:0] LEN_OVERHEAD = 8'd3;

	// Which byte the datapath places in the output register.
	localparam logic [2:0] SEL_LEN   = 3'd0;
	localparam logic [2:0] SEL_PID   = 3'd1;
	localparam logic [2:0] SEL_DATA  = 3'd2;
	localparam logic [2:0] SEL_CRC_L = 3'd3;
	localparam logic [2:0] SEL_CRC_H = 3'd4;

	typedef struct packed {
		logic       gather;      // store the input byte and update the CRC
		logic       toggle_clr;  // next packet uses DATA1
		logic       toggle_flip; // start of a packet: alternate the PID
		logic       out_load;    // load the output register
		logic [2:0] sel;         // byte source for the output register
		logic       first;
		logic       last;
		logic       run_last;
		logic       idx_step;    // advance the read pointer over the stored bytes
		logic       pkt_done;    // packet sent: empty the gather buffer
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;   // output register can take a byte this cycle
		logic count_zero; // no data bytes gathered
		logic full_next;  // one more byte fills the packet
		logic data_last;  // read pointer is on the last gathered byte
	} ctrl_sts_t;

	// One byte through the reflected CRC-16, a bit at a time.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
			input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- design/ufr_ctrl.sv -----
// Controller of the USB data packet framer: decodes input beats and walks
// each packet through length, PID, data and CRC bytes. Uses ufr_pkg.
module ufr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        operation,
	input  ufr_pkg::ctrl_sts_t sts,
	output ufr_pkg::ctrl_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LEN   = 3'd1;
	localparam logic [2:0] ST_PID   = 3'd2;
	localparam logic [2:0] ST_DATA  = 3'd3;
	localparam logic [2:0] ST_CRC_L = 3'd4;
	localparam logic [2:0] ST_CRC_H = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       extra_q;
	logic       extra_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		extra_d = extra_q;
		cmd     = '0;
		cmd.sel = ufr_pkg::SEL_LEN;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (operation)
						ufr_pkg::OP_DATA: begin
							cmd.gather = 1'b1;
							extra_d    = 1'b0;
							if (sts.full_next) begin
								state_d = ST_LEN;
							end
						end
						ufr_pkg::OP_FINAL: begin
							// A final byte that fills the packet is followed by an empty one.
							cmd.gather = 1'b1;
							extra_d    = sts.full_next;
							state_d    = ST_LEN;
						end
						ufr_pkg::OP_END: begin
							extra_d = 1'b0;
							state_d = ST_LEN;
						end
						default: begin
							cmd.toggle_clr = 1'b1;
						end
					endcase
				end
			end
			ST_LEN: begin
				cmd.sel         = ufr_pkg::SEL_LEN;
				cmd.first       = 1'b1;
				cmd.out_load    = sts.out_free;
				cmd.toggle_flip = sts.out_free;
				if (sts.out_free) begin
					state_d = ST_PID;
				end
			end
			ST_PID: begin
				cmd.sel      = ufr_pkg::SEL_PID;
				cmd.out_load = sts.out_free;
				if (sts.out_free) begin
					state_d = sts.count_zero ? ST_CRC_L : ST_DATA;
				end
			end
			ST_DATA: begin
				cmd.sel      = ufr_pkg::SEL_DATA;
				cmd.out_load = sts.out_free;
				cmd.idx_step = sts.out_free;
				if (sts.out_free && sts.data_last) begin
					state_d = ST_CRC_L;
				end
			end
			ST_CRC_L: begin
				cmd.sel      = ufr_pkg::SEL_CRC_L;
				cmd.out_load = sts.out_free;
				if (sts.out_free) begin
					state_d = ST_CRC_H;
				end
			end
			ST_CRC_H: begin
				cmd.sel      = ufr_pkg::SEL_CRC_H;
				cmd.last     = 1'b1;
				cmd.run_last = !extra_q;
				cmd.out_load = sts.out_free;
				cmd.pkt_done = sts.out_free;
				if (sts.out_free) begin
					state_d = extra_q ? ST_LEN : ST_IDLE;
					extra_d = 1'b0;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			extra_q <= 1'b0;
		end else begin
			state_q <= state_d;
			extra_q <= extra_d;
		end
	end

endmodule

// ----- design/ufr_datapath.sv -----
// Datapath of the USB data packet framer: gather buffer, CRC, PID toggle,
// PID registers and the output register. Uses ufr_pkg; driven by ufr_ctrl.
module ufr_datapath #(
	parameter int CHUNK_BYTES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ufr_pkg::ctrl_cmd_t             cmd,
	output ufr_pkg::ctrl_sts_t             sts,
	input  logic [7:0]                     message_byte,
	input  logic                           cfg_we,
	input  logic [ufr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [7:0]                     out_byte,
	output logic                           out_first,
	output logic                           out_last,
	output logic                           out_run_last
);

	localparam int CW = $clog2(CHUNK_BYTES + 1);
	localparam int IW = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
	localparam logic [CW-1:0] FULL_M1 = CW'(CHUNK_BYTES - 1);

	logic [7:0]    chunk_mem [CHUNK_BYTES];
	logic [7:0]    rd_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] idx_d;
	logic [CW-1:0] count_q;
	logic [15:0]   crc_q;
	logic          toggle_q;
	logic [7:0]    pid0_q;
	logic [7:0]    pid1_q;
	logic [15:0]   crc_out;
	logic [7:0]    byte_mux;
	logic          valid_q;
	logic          data_last;

	assign data_last = ((CW'(idx_q) + CW'(1)) == count_q);
	assign crc_out   = ~crc_q;

	assign sts.out_free   = !valid_q || out_ready;
	assign sts.count_zero = (count_q == '0);
	assign sts.full_next  = (count_q == FULL_M1);
	assign sts.data_last  = data_last;

	// The read address runs one step ahead so the registered read is ready in time.
	always_comb begin
		if (cmd.idx_step) begin
			idx_d = data_last ? '0 : idx_q + IW'(1);
		end else begin
			idx_d = idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.gather) begin
			chunk_mem[count_q[IW-1:0]] <= message_byte;
		end
		rd_q <= chunk_mem[idx_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			count_q  <= '0;
			crc_q    <= ufr_pkg::CRC_INIT;
			toggle_q <= 1'b0;
			pid0_q   <= ufr_pkg::PID_DATA0_RESET;
			pid1_q   <= ufr_pkg::PID_DATA1_RESET;
		end else begin
			idx_q <= idx_d;
			if (cmd.pkt_done) begin
				count_q <= '0;
				crc_q   <= ufr_pkg::CRC_INIT;
			end else if (cmd.gather) begin
				count_q <= count_q + CW'(1);
				crc_q   <= ufr_pkg::crc16_byte(crc_q, message_byte);
			end
			if (cmd.toggle_clr) begin
				toggle_q <= 1'b0;
			end else if (cmd.toggle_flip) begin
				toggle_q <= ~toggle_q;
			end
			if (cfg_we) begin
				if (cfg_index == ufr_pkg::REG_PID_DATA0) begin
					pid0_q <= cfg_data;
				end else if (cfg_index == ufr_pkg::REG_PID_DATA1) begin
					pid1_q <= cfg_data;
				end
			end
		end
	end

	always_comb begin
		case (cmd.sel)
			ufr_pkg::SEL_LEN:   byte_mux = 8'(count_q) + ufr_pkg::LEN_OVERHEAD;
			ufr_pkg::SEL_PID:   byte_mux = toggle_q ? pid1_q : pid0_q;
			ufr_pkg::SEL_DATA:  byte_mux = rd_q;
			ufr_pkg::SEL_CRC_L: byte_mux = crc_out[7:0];
			ufr_pkg::SEL_CRC_H: byte_mux = crc_out[15:8];
			default:            byte_mux = 8'h00;
		endcase
	end

	// Output register: payload has no reset, only the valid flag does.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_byte     <= byte_mux;
			out_first    <= cmd.first;
			out_last     <= cmd.last;
			out_run_last <= cmd.run_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid = valid_q;

endmodule

// ----- design/usb_data_packet_framer.sv -----
// Top level of the USB data packet framer: joins the controller and the datapath
// and maps them onto the stream and configuration ports. Uses ufr_pkg,
// ufr_ctrl and ufr_datapath.
//
// Channel   Direction  Beat contents
// s_*       in         tdata[7:0] message_byte; tuser[1:0] operation
// m_*       out        tdata[7:0] packet_byte; tuser[0] packet_first,
//                      tuser[1] run_last; tlast packet_last
// cfg_*     in         cfg_index selects the register, cfg_data is the value
//
// An input beat that produces no bytes (a plain data byte, a toggle reset) keeps
// the controller idle, so such beats can be accepted on every cycle. A beat that
// closes a packet of n data bytes is followed by the emission of n + 4 bytes, one
// output byte per cycle, and of a further 4 bytes when a trailing empty packet
// follows; s_tready is low for that time. The emission rate is set by the single
// output register, which the packet sequencer fills one byte per cycle.
// Stalls on m_tready simply hold the sequencer; the stored bytes are read from
// a small buffer with a registered read, addressed one step ahead.
// arst_n clears the gather count, the CRC, the PID toggle (next packet uses
// DATA1) and restores the PID codes to their defaults; no clearing pass is needed.
module usb_data_packet_framer #(
	parameter int CHUNK_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] message_byte
	input  logic [1:0]                    s_tuser,   // [1:0] operation
	// Output stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] packet_byte
	output logic [1:0]                    m_tuser,   // [0] packet_first, [1] run_last
	output logic                          m_tlast,   // packet_last
	// Configuration writes.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ufr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);

	ufr_pkg::ctrl_cmd_t cmd;
	ufr_pkg::ctrl_sts_t sts;
	logic               first_bit;
	logic               run_last_bit;

	// Registers are plain flops, so a write can always be taken at once.
	assign cfg_ready = 1'b1;

	ufr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.operation (s_tuser),
		.sts       (sts),
		.cmd       (cmd)
	);

	ufr_datapath #(
		.CHUNK_BYTES (CHUNK_BYTES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.message_byte (s_tdata),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_byte     (m_tdata),
		.out_first    (first_bit),
		.out_last     (m_tlast),
		.out_run_last (run_last_bit)
	);

	assign m_tuser = {run_last_bit, first_bit};

endmodule

// ----- dv/usb_data_packet_framer_tb.sv -----
// Self-checking testbench for usb_data_packet_framer: message bytes go in on the
// input stream, framed packet bytes are checked against a behavioural predictor.
// Depends on ufr_pkg and the framer RTL only.
`timescale 1ns / 100ps

module usb_data_packet_framer_tb;

	localparam int CHUNK = 8;

	// Register indexes that map to no register; writes to them must be dropped.
	localparam logic [ufr_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [ufr_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	// One framed output beat as the checker expects it.
	typedef struct packed {
		logic [7:0] pkt_byte;
		logic       pkt_first;
		logic       pkt_last;
		logic       run_end;
	} framed_beat_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [7:0]                    s_tdata;
	logic [1:0]                    s_tuser;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [7:0]                    m_tdata;
	logic [1:0]                    m_tuser;
	logic                          m_tlast;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [ufr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0]                    cfg_data;

	// Predictor state: PID codes, the bytes of the packet being gathered, the
	// running CRC over them and which PID the previous packet carried.
	logic [7:0]   pid0_code;
	logic [7:0]   pid1_code;
	logic [7:0]   gathered [CHUNK];
	int unsigned  gathered_n;
	logic [15:0]  crc_acc;
	logic         prev_was_data1;

	// Framed beats predicted but not yet seen on the output.
	framed_beat_t framed_q[$];

	// Idling percentages for each side, and the long receiver hold-off.
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	int   hold_cycles = 0;
	logic rx_hold = 1'b0;

	int mismatches = 0;
	int beats_in = 0;
	int beats_out = 0;
	int packets_out = 0;
	int reg_writes = 0;

	usb_data_packet_framer #(
		.CHUNK_BYTES(CHUNK)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Reflected CRC-16, fed least significant bit first: each bit is folded
	// into the feedback term before the shift.
	function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c  = c >> 1;
			if (fb) begin
				c = c ^ 16'hA001;
			end
		end
		return c;
	endfunction

	function automatic void framer_reset();
		pid0_code      = ufr_pkg::PID_DATA0_RESET;
		pid1_code      = ufr_pkg::PID_DATA1_RESET;
		gathered_n     = 0;
		crc_acc        = 16'hFFFF;
		prev_was_data1 = 1'b0;
		framed_q.delete();
	endfunction

	function automatic void push_beat(input logic [7:0] b, input logic f, input logic l);
		framed_beat_t e;
		e.pkt_byte  = b;
		e.pkt_first = f;
		e.pkt_last  = l;
		e.run_end   = 1'b0;
		framed_q.push_back(e);
	endfunction

	// Emits the gathered bytes as one packet and empties the gather buffer.
	function automatic void frame_packet();
		logic [15:0] crc_out;
		logic [7:0]  pid;
		crc_out        = ~crc_acc;
		prev_was_data1 = ~prev_was_data1;
		pid            = prev_was_data1 ? pid1_code : pid0_code;
		push_beat(8'(gathered_n + 3), 1'b1, 1'b0);
		push_beat(pid, 1'b0, 1'b0);
		for (int i = 0; i < gathered_n; i++) begin
			push_beat(gathered[i], 1'b0, 1'b0);
		end
		push_beat(crc_out[7:0], 1'b0, 1'b0);
		push_beat(crc_out[15:8], 1'b0, 1'b1);
		gathered_n = 0;
		crc_acc    = 16'hFFFF;
	endfunction

	function automatic void gather_byte(input logic [7:0] b);
		if (gathered_n < CHUNK) begin
			gathered[gathered_n] = b;
			gathered_n++;
			crc_acc = crc16_fold(crc_acc, b);
		end
	endfunction

	// Works out the beats that one accepted input beat produces and queues them.
	function automatic void predict_framing(input logic [1:0] op, input logic [7:0] b);
		int           queued;
		framed_beat_t tail;
		queued = framed_q.size();
		case (op)
			ufr_pkg::OP_DATA: begin
				gather_byte(b);
				if (gathered_n >= CHUNK) begin
					frame_packet();
				end
			end
			ufr_pkg::OP_FINAL: begin
				gather_byte(b);
				// A message ending on a full packet is closed by an empty one.
				if (gathered_n >= CHUNK) begin
					frame_packet();
				end
				frame_packet();
			end
			ufr_pkg::OP_END: begin
				frame_packet();
			end
			default: begin
				// Toggle reset keeps the gathered bytes and emits nothing.
				prev_was_data1 = 1'b0;
			end
		endcase
		if (framed_q.size() > queued) begin
			tail = framed_q.pop_back();
			tail.run_end = 1'b1;
			framed_q.push_back(tail);
		end
	endfunction

	// ------------------------------------------------------------------
	// Output side: ready generation, hold-off and checking
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
	end

	// The long hold-off runs in its own process so that the sender keeps offering
	// beats while the output is blocked.
	initial begin : hold_off
		forever begin
			wait (hold_cycles > 0);
			@(posedge clk);
			rx_hold <= 1'b1;
			repeat (hold_cycles) @(posedge clk);
			rx_hold <= 1'b0;
			hold_cycles = 0;
		end
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_output
		framed_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			beats_out++;
			if (m_tlast === 1'b1) begin
				packets_out++;
			end
			if (framed_q.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata, 8'h00);
			end else begin
				want = framed_q.pop_front();
				if (m_tdata !== want.pkt_byte) begin
					report_mismatch("packet_byte", m_tdata, want.pkt_byte);
				end
				if (m_tuser[0] !== want.pkt_first) begin
					report_mismatch("packet_first", {7'd0, m_tuser[0]}, {7'd0, want.pkt_first});
				end
				if (m_tlast !== want.pkt_last) begin
					report_mismatch("packet_last", {7'd0, m_tlast}, {7'd0, want.pkt_last});
				end
				if (m_tuser[1] !== want.run_end) begin
					report_mismatch("run_last", {7'd0, m_tuser[1]}, {7'd0, want.run_end});
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Offers one beat after a random gap and returns once it has been taken.
	// tvalid is left high so that back-to-back beats need no second assignment
	// in the same step; phases lower it in wait_idle.
	task automatic send_beat(input logic [1:0] op, input logic [7:0] b);
		int gap;
		gap = 0;
		while (gap < 12 && $urandom_range(99) < tx_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= b;
		do @(posedge clk); while (s_tready !== 1'b1);
		predict_framing(op, b);
		beats_in++;
	endtask

	// Lowers the input, waits until every predicted beat has come out and then
	// lets the block settle, so that registers can be written safely.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (framed_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// One register write; the caller lowers cfg_valid after its last write.
	task automatic write_reg(input logic [ufr_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == ufr_pkg::REG_PID_DATA0) begin
			pid0_code = val;
		end else if (idx == ufr_pkg::REG_PID_DATA1) begin
			pid1_code = val;
		end
		reg_writes++;
	endtask

	function automatic logic [7:0] random_byte();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5) begin
			return 8'h00;
		end else if (roll < 10) begin
			return 8'hFF;
		end
		return 8'($urandom_range(255));
	endfunction

	// A well-formed message of random length and content, now and then with a
	// toggle reset in the middle; about one call in eight is a lone stray beat.
	task automatic send_message();
		int         len;
		int         roll;
		logic [1:0] op;
		roll = $urandom_range(99);
		if (roll < 12) begin
			op = 2'($urandom_range(3));
			send_beat(op, 8'($urandom_range(255)));
			return;
		end
		roll = $urandom_range(99);
		if (roll < 70) begin
			len = $urandom_range(1, 10);
		end else if (roll < 85) begin
			len = $urandom_range(11, 24);
		end else begin
			// Lengths that end exactly on a packet boundary.
			len = CHUNK * $urandom_range(1, 2);
		end
		for (int k = 0; k < len - 1; k++) begin
			if ($urandom_range(99) < 4) begin
				send_beat(ufr_pkg::OP_TOGGLE_RST, random_byte());
			end
			send_beat(ufr_pkg::OP_DATA, random_byte());
		end
		if ($urandom_range(1)) begin
			send_beat(ufr_pkg::OP_FINAL, random_byte());
		end else begin
			send_beat(ufr_pkg::OP_DATA, random_byte());
			send_beat(ufr_pkg::OP_END, random_byte());
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Packet rules with the reset PID codes: empty packets, a single byte,
	// extreme data values, full packets closed by data and by a final byte, and
	// a toggle reset that must keep the bytes already gathered.
	task automatic test_packet_rules();
		send_beat(ufr_pkg::OP_END, 8'hFF);                 // empty packet, DATA1
		send_beat(ufr_pkg::OP_FINAL, 8'h00);               // one byte, DATA0
		send_beat(ufr_pkg::OP_DATA, 8'hFF);
		send_beat(ufr_pkg::OP_FINAL, 8'h00);
		send_beat(ufr_pkg::OP_TOGGLE_RST, 8'hA5);
		for (int k = 0; k < CHUNK; k++) begin     // full packet from plain data
			send_beat(ufr_pkg::OP_DATA, (k % 2) ? 8'hFF : 8'h00);
		end
		for (int k = 0; k < CHUNK - 1; k++) begin // full packet closed by the final
			send_beat(ufr_pkg::OP_DATA, 8'(8'h80 >> k));    // byte, then an empty one
		end
		send_beat(ufr_pkg::OP_FINAL, 8'h7F);
		send_beat(ufr_pkg::OP_DATA, 8'hA5);
		send_beat(ufr_pkg::OP_TOGGLE_RST, 8'h00);
		send_beat(ufr_pkg::OP_END, 8'h5A);
		wait_idle();
	endtask

	// Writes both PID codes, plus the spare indexes which must change nothing.
	task automatic test_pid_codes(input logic [7:0] d0, input logic [7:0] d1);
		write_reg(ufr_pkg::REG_PID_DATA0, d0);
		write_reg(REG_SPARE_A, ~d0);
		write_reg(ufr_pkg::REG_PID_DATA1, d1);
		write_reg(REG_SPARE_B, ~d1);
		cfg_valid <= 1'b0;
		// A short message so that both codes appear on the output.
		send_beat(ufr_pkg::OP_END, 8'h00);
		send_beat(ufr_pkg::OP_FINAL, random_byte());
		wait_idle();
	endtask

	task automatic test_random_messages(input int tx_pct, input int rx_pct, input int beats);
		int stop_at;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		stop_at = beats_in + beats;
		while (beats_in < stop_at) begin
			send_message();
		end
		wait_idle();
	endtask

	// The receiver stops for a long stretch while full packets keep arriving,
	// so the output register and the sequencer back up into the input.
	task automatic test_output_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_cycles = 400;
		for (int k = 0; k < 3 * CHUNK; k++) begin
			send_beat(ufr_pkg::OP_DATA, random_byte());
		end
		send_beat(ufr_pkg::OP_FINAL, random_byte());
		for (int m = 0; m < 3; m++) begin
			send_message();
		end
		wait_idle();
	endtask

	initial begin : run_time_limit
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : main
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = 8'h00;
		s_tuser   = ufr_pkg::OP_DATA;
		cfg_valid = 1'b0;
		cfg_index = ufr_pkg::REG_PID_DATA0;
		cfg_data  = 8'h00;
		framer_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 34;
		rx_idle_pct = 72;
		test_packet_rules();

		test_pid_codes(8'h00, 8'hFF);
		test_random_messages(34, 72, 125);

		test_pid_codes(8'hFF, 8'h00);
		test_random_messages(72, 34, 125);

		test_pid_codes(8'($urandom_range(255)), 8'($urandom_range(255)));
		test_random_messages(0, 0, 125);

		test_output_backpressure();

		$display("Sent %0d input beats and checked %0d output beats in %0d packets.",
			beats_in, beats_out, packets_out);
		$display("Made %0d register writes; %0d mismatches found.", reg_writes, mismatches);
		if (mismatches == 0 && framed_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/ufr_pkg.sv
design/ufr_ctrl.sv
design/ufr_datapath.sv
design/usb_data_packet_framer.sv
dv/usb_data_packet_framer_tb.sv
